FILE: hw/rtl/mcof_pkg.sv
// Shared codes and defaults for the multi-channel overwrite FIFO.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcof_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_QUEUES_DEF  = 4;

    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int CHAN_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int LOST_W    = 32;

    localparam logic [FUNC_W-1:0] FN_FLUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

endpackage

FILE: hw/rtl/multi_channel_overwrite_fifo_unit.sv
// Top level of the multi-channel overwrite FIFO: request sequencer.
// Uses mcof_pkg, mcof_chan_ram and mcof_word_ram.
`timescale 1ns / 1ps

// Several circular word FIFOs share one word store. Each request on the
// input channel (in_valid / in_stall) names a channel and a function:
// flush, write or read. A write to a full channel replaces the oldest word
// and counts it as lost. A read of an empty channel reports an empty status.
// Every request gives exactly one result on the output channel
// (out_valid / out_stall).
// Steps: a request is taken in the idle state and its channel record is
// read from the record memory; the next cycle modifies and writes it back
// (and addresses the word memory); in the done state the result is
// registered in the output register. The read-modify-write of the record
// memory handles one request at a time: no new request is taken until the
// last one has left the done state.
// While the receiver stalls, the result waits in the output register and
// the next request can still be taken; it then waits in its last step
// until the output register frees.
// Reset clears all channel records (valid bits) and both handshakes; the
// word store is not cleared.

module multi_channel_overwrite_fifo_unit
    import mcof_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [WORD_W-1:0]   write_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [WORD_W-1:0]   read_data,
    output logic [OCC_W-1:0]    occupancy,
    output logic [LOST_W-1:0]   lost_count
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CH_AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW    = (CH_AW > CHAN_W) ? CH_AW : CHAN_W;
    localparam int WORDS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(WORDS);

    typedef struct packed
    {
        logic [LOST_W-1:0] lost;
        logic [CW-1:0]     cnt;
        logic [PW-1:0]     wp;
        logic [PW-1:0]     rp;
    } chan_t;

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_META = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0] func_reg;
    logic [CH_AW-1:0]  ch_reg;
    logic [WORD_W-1:0] data_reg;
    logic              range_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [OCC_W-1:0]    res_occ_reg, res_occ_next;
    logic [LOST_W-1:0]   res_lost_reg, res_lost_next;
    logic                res_rd_reg, res_rd_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WORD_W-1:0]   out_data_reg;
    logic [OCC_W-1:0]    out_occ_reg;
    logic [LOST_W-1:0]   out_lost_reg;

    logic              accept;
    logic              out_free;
    logic [IW-1:0]     ch_ext;
    logic              in_range;
    logic [$bits(chan_t)-1:0] rec_q;
    chan_t             rec_cur, rec_new;
    logic              rec_we;
    logic              word_we, word_re;
    logic [AW-1:0]     word_waddr, word_raddr;
    logic [WORD_W-1:0] word_q;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign ch_ext   = IW'(channel);
    assign in_range = (32'(channel) < NUM_QUEUES);

    mcof_chan_ram #(
        .DEPTH (NUM_QUEUES),
        .AW    (CH_AW),
        .WIDTH ($bits(chan_t))
    ) u_chan_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ch_ext[CH_AW-1:0]),
        .rd_data (rec_q),
        .wr_en   (rec_we),
        .wr_addr (ch_reg),
        .wr_data (rec_new)
    );

    mcof_word_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (word_we),
        .wr_addr (word_waddr),
        .wr_data (data_reg),
        .rd_en   (word_re),
        .rd_addr (word_raddr),
        .rd_data (word_q)
    );

    assign rec_cur    = chan_t'(rec_q);
    assign word_waddr = AW'(32'(ch_reg) * QUEUE_DEPTH + 32'(rec_cur.wp));
    assign word_raddr = AW'(32'(ch_reg) * QUEUE_DEPTH + 32'(rec_cur.rp));

    // modify the channel record fetched in the previous cycle
    always_comb
    begin
        rec_new         = rec_cur;
        rec_we          = 1'b0;
        word_we         = 1'b0;
        word_re         = 1'b0;
        res_status_next = res_status_reg;
        res_occ_next    = res_occ_reg;
        res_lost_next   = res_lost_reg;
        res_rd_next     = res_rd_reg;
        if (state_reg == S_META)
        begin
            res_status_next = ST_OK;
            res_rd_next     = 1'b0;
            unique case (func_reg)
                FN_FLUSH:
                begin
                    rec_new = '0;
                    rec_we  = range_reg;
                end
                FN_WRITE:
                begin
                    word_we    = range_reg;
                    rec_we     = range_reg;
                    rec_new.wp = next_slot(rec_cur.wp);
                    if (rec_cur.cnt >= CW'(QUEUE_DEPTH))
                    begin
                        rec_new.rp      = next_slot(rec_cur.rp);
                        rec_new.lost    = rec_cur.lost + 1'b1;
                        res_status_next = ST_OVERWRITE;
                    end
                    else
                    begin
                        rec_new.cnt = rec_cur.cnt + 1'b1;
                    end
                end
                FN_READ:
                begin
                    if (rec_cur.cnt == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        word_re     = range_reg;
                        rec_we      = range_reg;
                        res_rd_next = 1'b1;
                        rec_new.rp  = next_slot(rec_cur.rp);
                        rec_new.cnt = rec_cur.cnt - 1'b1;
                    end
                end
                default:
                begin
                    // unused function code: report the record unchanged
                end
            endcase
            res_occ_next  = OCC_W'(rec_new.cnt);
            res_lost_next = rec_new.lost;
            if (!range_reg)
            begin
                // channel beyond the configured count: drop, report zeros
                res_status_next = ST_OK;
                res_rd_next     = 1'b0;
                res_occ_next    = '0;
                res_lost_next   = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register frees
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            ch_reg    <= ch_ext[CH_AW-1:0];
            data_reg  <= write_data;
            range_reg <= in_range;
        end
        res_status_reg <= res_status_next;
        res_occ_reg    <= res_occ_next;
        res_lost_reg   <= res_lost_next;
        res_rd_reg     <= res_rd_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_rd_reg ? word_q : '0;
            out_occ_reg    <= res_occ_reg;
            out_lost_reg   <= res_lost_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_data  = out_data_reg;
    assign occupancy  = out_occ_reg;
    assign lost_count = out_lost_reg;

endmodule

FILE: hw/rtl/mcof_word_ram.sv
// Shared word store for all channels: one write port, one read port.
// Synchronous read with registered data; depends on mcof_pkg.
`timescale 1ns / 1ps

module mcof_word_ram
    import mcof_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF * NUM_QUEUES_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mcof_chan_ram.sv
// Per-channel state record store (pointers, count, lost counter).
// Valid bits cleared at reset make an unwritten record read as zero; uses mcof_pkg.
`timescale 1ns / 1ps

module mcof_chan_ram
    import mcof_pkg::*;
#(
    parameter int DEPTH = NUM_QUEUES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int WIDTH = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // a record never written reads as its reset value
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
